// ----- rtl/core/sle_pkg.sv -----
// Shared widths, request codes and status codes of the sequential list engine.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int MODE_W  = 3;
  localparam int POS_W   = 5;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GET    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/sle_ram.sv -----
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
  parameter int DEPTH = sle_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire                              clk,
  input  wire                              wr_en,
  input  wire  [AW-1:0]                    wr_addr,
  input  wire  signed [sle_pkg::DATA_W-1:0] wr_data,
  input  wire                              rd_en,
  input  wire  [AW-1:0]                    rd_addr,
  output logic signed [sle_pkg::DATA_W-1:0] rd_data
);

  logic signed [sle_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic signed [sle_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/sequential_list_engine.sv -----
// Ordered list of signed words in a two-port store, with clear, insert, delete, get and locate.
//
// A request is taken when start is high and busy is low; its one result appears on the
// out_ ports for a single cycle, marked by out_strobe, and must be taken then (there is no
// back-pressure). busy is low again in the strobe cycle, so the next request may be issued
// there. Clear and any rejected request are answered straight from idle; get reads its
// entry; an insert moves the entries at and after its position up, from the tail, then
// writes the new word; a delete reads its entry, then moves each later entry down; a
// locate reads from the head until a hit or the end of the list. The longest request is
// a delete at the head of a full list. Pace is set by the store: at most one entry is
// read and one written per cycle, and a single index counter walks the list under the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module sequential_list_engine #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [sle_pkg::MODE_W-1:0]         in_mode,
  input  wire  [sle_pkg::POS_W-1:0]          in_position,
  input  wire  signed [sle_pkg::DATA_W-1:0]  in_value,
  output logic                               out_strobe,
  output logic [sle_pkg::STAT_W-1:0]         out_status,
  output logic signed [sle_pkg::DATA_W-1:0]  out_value_out,
  output logic [sle_pkg::POS_W-1:0]          out_found_position,
  output logic [sle_pkg::POS_W-1:0]          out_length_out
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = sle_pkg::POS_W;
  localparam int CW = ((LW > PW) ? LW : PW) + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_UP    = 6'b000010,
    S_FETCH = 6'b000100,
    S_GRAB  = 6'b001000,
    S_DN    = 6'b010000,
    S_LOC   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] tgt_r, tgt_nxt;
  logic [LW-1:0] pend_idx_r, pend_idx_nxt;
  logic          pend_r, pend_nxt;
  logic          is_del_r, is_del_nxt;
  logic signed [sle_pkg::DATA_W-1:0] value_r, value_nxt;

  logic                               strobe_r, strobe_nxt;
  logic [sle_pkg::STAT_W-1:0]         status_r, status_nxt;
  logic signed [sle_pkg::DATA_W-1:0]  vout_r, vout_nxt;
  logic [PW-1:0]                      found_r, found_nxt;
  logic [PW-1:0]                      olen_r, olen_nxt;

  logic                               wr_en;
  logic [AW-1:0]                      wr_addr;
  logic signed [sle_pkg::DATA_W-1:0]  wr_data;
  logic                               rd_en;
  logic [AW-1:0]                      rd_addr;
  logic signed [sle_pkg::DATA_W-1:0]  rd_data;

  logic [CW-1:0] pos_c, len_c, pos_m1, pend_pos, olen_ext;
  logic [LW-1:0] idx_m1, idx_p1, tgt_p1;
  logic          full, ins_ok, acc_ok, hit;

  sle_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign pos_c    = CW'(in_position);
  assign len_c    = CW'(len_r);
  assign pos_m1   = pos_c - CW'(1);
  assign pend_pos = CW'(pend_idx_r) + CW'(1);
  assign idx_m1   = idx_r - LW'(1);
  assign idx_p1   = idx_r + LW'(1);
  assign tgt_p1   = tgt_r + LW'(1);
  assign full     = (len_r == LW'(CAPACITY));
  assign ins_ok   = (pos_c != '0) && (pos_c <= len_c + CW'(1));
  assign acc_ok   = (pos_c != '0) && (pos_c <= len_c);
  assign hit      = pend_r && (rd_data == value_r);

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    tgt_nxt      = tgt_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    is_del_nxt   = is_del_r;
    value_nxt    = value_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    vout_nxt     = vout_r;
    found_nxt    = found_r;
    wr_en        = 1'b0;
    wr_addr      = pend_idx_r[AW-1:0];
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          value_nxt = in_value;
          tgt_nxt   = pos_m1[LW-1:0];
          vout_nxt  = '0;
          found_nxt = '0;
          unique case (in_mode)
            sle_pkg::MODE_CLEAR: begin
              len_nxt    = '0;
              strobe_nxt = 1'b1;
              status_nxt = sle_pkg::ST_OK;
            end
            sle_pkg::MODE_INSERT: begin
              if (full) begin
                strobe_nxt = 1'b1;
                status_nxt = sle_pkg::ST_FULL;
              end else if (!ins_ok) begin
                strobe_nxt = 1'b1;
                status_nxt = sle_pkg::ST_BAD;
              end else begin
                state_nxt = S_UP;
                idx_nxt   = len_r;
                pend_nxt  = 1'b0;
              end
            end
            sle_pkg::MODE_DELETE, sle_pkg::MODE_GET: begin
              if (!acc_ok) begin
                strobe_nxt = 1'b1;
                status_nxt = sle_pkg::ST_BAD;
              end else begin
                state_nxt  = S_FETCH;
                is_del_nxt = (in_mode == sle_pkg::MODE_DELETE);
              end
            end
            sle_pkg::MODE_LOCATE: begin
              state_nxt = S_LOC;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
            end
            default: begin
              strobe_nxt = 1'b1;
              status_nxt = sle_pkg::ST_BAD;
            end
          endcase
        end
      end

      // shift up from the tail, then drop the new word into the gap
      S_UP: begin
        if (pend_r) begin
          wr_en = 1'b1;
        end else if (idx_r == tgt_r) begin
          wr_en   = 1'b1;
          wr_addr = tgt_r[AW-1:0];
          wr_data = value_r;
        end
        if (idx_r != tgt_r) begin
          rd_en        = 1'b1;
          rd_addr      = idx_m1[AW-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_m1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            len_nxt    = len_r + LW'(1);
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
            status_nxt = sle_pkg::ST_OK;
          end
        end
      end

      S_FETCH: begin
        rd_en     = 1'b1;
        rd_addr   = tgt_r[AW-1:0];
        state_nxt = S_GRAB;
      end

      S_GRAB: begin
        vout_nxt = rd_data;
        if (is_del_r) begin
          state_nxt = S_DN;
          idx_nxt   = tgt_p1;
          pend_nxt  = 1'b0;
        end else begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          status_nxt = sle_pkg::ST_OK;
        end
      end

      // close the gap: each later entry moves down by one
      S_DN: begin
        if (pend_r) begin
          wr_en = 1'b1;
        end
        if (idx_r != len_r) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_m1;
          idx_nxt      = idx_p1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            len_nxt    = len_r - LW'(1);
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
            status_nxt = sle_pkg::ST_OK;
          end
        end
      end

      S_LOC: begin
        priority if (hit) begin
          pend_nxt   = 1'b0;
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          status_nxt = sle_pkg::ST_OK;
          found_nxt  = pend_pos[PW-1:0];
        end else if (idx_r != len_r) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_p1;
        end else begin
          pend_nxt   = 1'b0;
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          status_nxt = sle_pkg::ST_BAD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  assign olen_ext = CW'(len_nxt);
  assign olen_nxt = strobe_nxt ? olen_ext[PW-1:0] : olen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      len_r    <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    tgt_r      <= tgt_nxt;
    pend_idx_r <= pend_idx_nxt;
    is_del_r   <= is_del_nxt;
    value_r    <= value_nxt;
    status_r   <= status_nxt;
    vout_r     <= vout_nxt;
    found_r    <= found_nxt;
    olen_r     <= olen_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_value_out      = vout_r;
  assign out_found_position = found_r;
  assign out_length_out     = olen_r;

`ifndef ASSERT_OFF
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY))
    else $error("list length above capacity");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (state_r == S_IDLE))
    else $error("result strobed while sequencer busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (strobe_r || busy))
    else $error("accepted transaction neither answered nor in progress");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("store transfer left pending in idle");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_sequential_list_engine.sv -----
// Self-checking testbench for the sequential list engine: directed and random requests.
`timescale 1ns / 1ps
`default_nettype none

module tb_sequential_list_engine;
  import sle_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int MAX_GAP      = 17;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = CAP + 8;
  localparam int RANDOM_ITEMS = 1750;
  localparam int REPORT_MAX   = 10;

  localparam logic [MODE_W-1:0] MODE_RSVD_FIRST = MODE_LOCATE + 1'b1;
  localparam logic [MODE_W-1:0] MODE_RSVD_LAST  = {MODE_W{1'b1}};

  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_ONES = {DATA_W{1'b1}};

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         found;
    logic [POS_W-1:0]         length;
  } list_result_t;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     start       = 1'b0;
  logic [MODE_W-1:0]        in_mode     = MODE_CLEAR;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic                     busy;
  logic                     out_strobe;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_value_out;
  logic [POS_W-1:0]         out_found_position;
  logic [POS_W-1:0]         out_length_out;

  // in-bench copy of the list
  logic signed [DATA_W-1:0] shadow_words [CAP];
  int                       shadow_len = 0;
  logic signed [DATA_W-1:0] word_pool [8];

  list_result_t             pending_results [$];
  list_result_t             due;
  int                       mismatches  = 0;
  int                       idle_cycles = 0;
  bit                       no_gaps     = 1'b0;

  sequential_list_engine #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_value_out     (out_value_out),
    .out_found_position(out_found_position),
    .out_length_out    (out_length_out)
  );

  always #5 clk = ~clk;

  function automatic list_result_t apply_list_request(input logic [MODE_W-1:0] mode,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic signed [DATA_W-1:0] word);
    list_result_t res;
    int           k;
    int           p;
    res.status = ST_BAD;
    res.value  = '0;
    res.found  = '0;
    p = int'(pos);
    case (mode)
      MODE_CLEAR: begin
        shadow_len = 0;
        res.status = ST_OK;
      end
      MODE_INSERT: begin
        if (shadow_len >= CAP) begin
          res.status = ST_FULL;
        end else if (p >= 1 && p <= shadow_len + 1) begin
          for (k = shadow_len; k > p - 1; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[p-1] = word;
          shadow_len++;
          res.status = ST_OK;
        end
      end
      MODE_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          res.value = shadow_words[p-1];
          for (k = p - 1; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k+1];
          shadow_len--;
          res.status = ST_OK;
        end
      end
      MODE_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          res.value  = shadow_words[p-1];
          res.status = ST_OK;
        end
      end
      MODE_LOCATE: begin
        for (k = 0; k < shadow_len && res.status != ST_OK; k++) begin
          if (shadow_words[k] == word) begin
            res.found  = POS_W'(k + 1);
            res.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    res.length = POS_W'(shadow_len);
    return res;
  endfunction

  // start is left high after acceptance so back-to-back requests need no toggle
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] word);
    int gap;
    if ($urandom_range(0, 31) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode     <= mode;
    in_position <= pos;
    in_value    <= word;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_request(mode, pos, word));
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic test_empty_list();
    int m;
    send_request(MODE_CLEAR, 5'd0, WORD_MAX);
    send_request(MODE_GET, 5'd1, '0);
    send_request(MODE_DELETE, 5'd1, '0);
    send_request(MODE_LOCATE, 5'd0, '0);
    send_request(MODE_INSERT, 5'd0, WORD_ONES);
    send_request(MODE_INSERT, 5'd2, WORD_ONES);
    for (m = int'(MODE_RSVD_FIRST); m <= int'(MODE_RSVD_LAST); m++)
      send_request(MODE_W'(m), 5'd1, WORD_ONES);
  endtask

  task automatic test_edge_positions();
    send_request(MODE_INSERT, 5'd1, WORD_MAX);
    send_request(MODE_INSERT, 5'd1, WORD_MIN);
    send_request(MODE_INSERT, 5'd3, '0);
    send_request(MODE_INSERT, 5'd5, WORD_ONES);
    send_request(MODE_INSERT, 5'd4, WORD_ONES);
    send_request(MODE_INSERT, 5'd2, '0);
    send_request(MODE_GET, 5'd0, '0);
    send_request(MODE_GET, 5'd1, '0);
    send_request(MODE_GET, 5'd5, '0);
    send_request(MODE_GET, 5'd6, '0);
    send_request(MODE_LOCATE, 5'd0, '0);
    send_request(MODE_LOCATE, 5'd31, WORD_ONES);
    send_request(MODE_LOCATE, 5'd1, 32'sh1234_5678);
    send_request(MODE_DELETE, 5'd7, '0);
    send_request(MODE_DELETE, 5'd6, '0);
    send_request(MODE_DELETE, 5'd1, '0);
    send_request(MODE_DELETE, 5'd2, '0);
  endtask

  task automatic test_full_list();
    int i;
    send_request(MODE_CLEAR, 5'd17, WORD_MIN);
    for (i = 0; i < CAP; i++)
      send_request(MODE_INSERT, POS_W'($urandom_range(1, shadow_len + 1)), pick_word());
    send_request(MODE_INSERT, 5'd0, WORD_MAX);
    send_request(MODE_INSERT, POS_W'(CAP + 1), WORD_MAX);
    send_request(MODE_INSERT, 5'd1, WORD_MAX);
    send_request(MODE_GET, POS_W'(CAP), '0);
    send_request(MODE_GET, POS_W'(CAP + 1), '0);
    send_request(MODE_LOCATE, 5'd0, shadow_words[CAP-1]);
    send_request(MODE_DELETE, POS_W'(CAP), '0);
    send_request(MODE_INSERT, POS_W'(CAP), WORD_MIN);
  endtask

  // fill and drain phases so the list spends time both empty and full
  task automatic test_random_traffic(input int n_items);
    int                       i;
    int                       r;
    bit                       filling;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] word;
    filling = 1'b1;
    for (i = 0; i < n_items; i++) begin
      if (shadow_len == CAP && $urandom_range(0, 5) == 0) filling = 1'b0;
      if (shadow_len == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 2)       mode = MODE_CLEAR;
      else if (r < 5)  mode = MODE_W'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
      else if (r < 45) mode = filling ? MODE_INSERT : MODE_DELETE;
      else if (r < 55) mode = filling ? MODE_DELETE : MODE_INSERT;
      else if (r < 75) mode = MODE_GET;
      else             mode = MODE_LOCATE;
      word = pick_word();
      if ($urandom_range(0, 9) == 0)
        pos = POS_W'($urandom_range(0, CAP + 1));
      else if (mode == MODE_INSERT)
        pos = POS_W'($urandom_range(1, (shadow_len < CAP) ? shadow_len + 1 : CAP + 1));
      else if (shadow_len > 0)
        pos = POS_W'($urandom_range(1, shadow_len));
      else
        pos = POS_W'($urandom_range(0, CAP + 1));
      if (mode == MODE_LOCATE && shadow_len > 0 && $urandom_range(0, 9) < 6)
        word = shadow_words[$urandom_range(0, shadow_len - 1)];
      send_request(mode, pos, word);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result with none pending: status %0d value %h found %0d len %0d",
                     $time, out_status, out_value_out, out_found_position, out_length_out);
        end else begin
          due = pending_results.pop_front();
          if (out_status !== due.status || out_value_out !== due.value ||
              out_found_position !== due.found || out_length_out !== due.length) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: mismatch exp status %0d value %h found %0d len %0d, got %0d %h %0d %0d",
                       $time, due.status, due.value, due.found, due.length, out_status,
                       out_value_out, out_found_position, out_length_out);
          end
        end
      end
      if ((start && !busy) || out_strobe) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int i;
    word_pool[0] = WORD_MIN;
    word_pool[1] = WORD_MAX;
    word_pool[2] = '0;
    word_pool[3] = WORD_ONES;
    word_pool[4] = 32'sd1;
    for (i = 5; i < 8; i++) word_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_edge_positions();
    test_full_list();
    test_random_traffic(RANDOM_ITEMS);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
